@@ sv/rbp_pkg.sv @@
`default_nettype none

package rbp_pkg;

  // Fixed field widths
  localparam int KIND_W   = 2;
  localparam int INDEX_W  = 6;
  localparam int OFFSET_W = 26;
  localparam int REFCNT_W = 16;
  localparam int FREE_W   = 7;
  localparam int STATUS_W = 2;
  localparam int FRAMES_W = 7;
  localparam int BYTES_W  = 21;

  // Configuration port
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = BYTES_W;

  // Defaults for the top-level parameters and queues
  localparam int MAX_FRAMES_DEF = 64;
  localparam int COUNT_BITS_DEF = 16;
  localparam int QUEUE_DEPTH    = 2;

  // Register limits and reset values
  localparam int FRAMES_RESET_REQ = 64;
  localparam logic [BYTES_W-1:0] BYTES_RESET = BYTES_W'(4096);
  localparam logic [BYTES_W-1:0] BYTES_LIMIT = BYTES_W'(1048576);

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_FRAMES = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_BYTES  = 1'b1;

  // Operation codes on the input beat
  localparam logic [KIND_W-1:0] KIND_ACQUIRE = 2'd0;
  localparam logic [KIND_W-1:0] KIND_REF     = 2'd1;
  localparam logic [KIND_W-1:0] KIND_UNREF   = 2'd2;

  // Result status codes
  localparam logic [STATUS_W-1:0] STAT_OK       = 2'd0;
  localparam logic [STATUS_W-1:0] STAT_EMPTY    = 2'd1;
  localparam logic [STATUS_W-1:0] STAT_RETURNED = 2'd2;
  localparam logic [STATUS_W-1:0] STAT_BAD      = 2'd3;

  typedef struct packed {
    logic [KIND_W-1:0]  kind;
    logic [INDEX_W-1:0] frame_index;
  } in_item_t;

  typedef struct packed {
    logic        [INDEX_W-1:0]  granted_index;
    logic        [OFFSET_W-1:0] byte_offset;
    logic signed [REFCNT_W-1:0] ref_count;
    logic        [FREE_W-1:0]   free_left;
    logic        [STATUS_W-1:0] status;
  } out_item_t;

  // Classified command handed from front to back
  typedef enum logic [1:0] {
    OP_ACQUIRE,
    OP_REF,
    OP_UNREF,
    OP_REJECT
  } cmd_op_t;

  typedef struct packed {
    cmd_op_t            op;
    logic [INDEX_W-1:0] idx;
  } cmd_t;

  // Pool configuration as seen by front and back
  typedef struct packed {
    logic [FRAMES_W-1:0] frames_in_use;
    logic [BYTES_W-1:0]  frame_bytes;
    logic                reload;
  } pool_cfg_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_EXEC,
    BK_MUL
  } bk_state_t;

  // Frame count after reset, limited by the pool size
  function automatic int reset_frames(input int max_frames);
    return (max_frames < FRAMES_RESET_REQ) ? max_frames : FRAMES_RESET_REQ;
  endfunction

endpackage

`default_nettype wire

@@ sv/rbp_fifo.sv @@
`default_nettype none

module rbp_fifo #(
  parameter type T     = logic,
  parameter int  DEPTH = rbp_pkg::QUEUE_DEPTH
) (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic push,
  input  wire T     wdata,
  output logic      full,
  input  wire logic pop,
  output T          rdata,
  output logic      empty
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  T               mem_r [DEPTH];
  logic [AW-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [AW-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]  count_r, count_nxt;
  logic           push_ok, pop_ok;

  assign full    = (count_r == CW'(DEPTH));
  assign empty   = (count_r == '0);
  assign push_ok = push && !full;
  assign pop_ok  = pop && !empty;
  assign rdata   = mem_r[rd_ptr_r];

  // Pointer wrap and occupancy
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    if (push_ok) begin
      wr_ptr_nxt = (wr_ptr_r == AW'(DEPTH - 1)) ? '0 : wr_ptr_r + AW'(1);
    end
    if (pop_ok) begin
      rd_ptr_nxt = (rd_ptr_r == AW'(DEPTH - 1)) ? '0 : rd_ptr_r + AW'(1);
    end
    unique case ({push_ok, pop_ok})
      2'b10:   count_nxt = count_r + CW'(1);
      2'b01:   count_nxt = count_r - CW'(1);
      default: count_nxt = count_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Storage, no reset
  always_ff @(posedge clk) begin
    if (push_ok) begin
      mem_r[wr_ptr_r] <= wdata;
    end
  end

endmodule

`default_nettype wire

@@ sv/rbp_front.sv @@
`default_nettype none

module rbp_front #(
  parameter int DEPTH = rbp_pkg::QUEUE_DEPTH
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire rbp_pkg::pool_cfg_t cfg,
  input  wire logic              sweeping,
  input  wire logic              in_push,
  input  wire rbp_pkg::in_item_t in_item,
  output logic                   in_full,
  input  wire logic              cmd_pop,
  output rbp_pkg::cmd_t          cmd,
  output logic                   cmd_empty
);

  rbp_pkg::cmd_t cmd_in;
  logic          q_full;
  logic          idx_bad;

  // Hold off beats while the pool is being rebuilt
  assign in_full = q_full || sweeping || cfg.reload;
  assign idx_bad = ({1'b0, in_item.frame_index} >= cfg.frames_in_use);

  // Classify the beat
  always_comb begin
    cmd_in.idx = in_item.frame_index;
    unique case (in_item.kind)
      rbp_pkg::KIND_ACQUIRE: cmd_in.op = rbp_pkg::OP_ACQUIRE;
      rbp_pkg::KIND_REF:     cmd_in.op = idx_bad ? rbp_pkg::OP_REJECT : rbp_pkg::OP_REF;
      rbp_pkg::KIND_UNREF:   cmd_in.op = idx_bad ? rbp_pkg::OP_REJECT : rbp_pkg::OP_UNREF;
      default: begin
        // unused kind answers bad with a zero index
        cmd_in.op  = rbp_pkg::OP_REJECT;
        cmd_in.idx = '0;
      end
    endcase
  end

  rbp_fifo #(
    .T     (rbp_pkg::cmd_t),
    .DEPTH (DEPTH)
  ) u_cmd_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (in_push && !in_full),
    .wdata (cmd_in),
    .full  (q_full),
    .pop   (cmd_pop),
    .rdata (cmd),
    .empty (cmd_empty)
  );

endmodule

`default_nettype wire

@@ sv/rbp_back.sv @@
`default_nettype none

module rbp_back #(
  parameter int MAX_FRAMES = rbp_pkg::MAX_FRAMES_DEF,
  parameter int COUNT_BITS = rbp_pkg::COUNT_BITS_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire rbp_pkg::pool_cfg_t cfg,
  output logic                    sweeping,
  input  wire logic               cmd_empty,
  input  wire rbp_pkg::cmd_t      cmd,
  output logic                    cmd_pop,
  input  wire logic               res_full,
  output logic                    res_push,
  output rbp_pkg::out_item_t      res
);

  localparam int IW = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1;
  localparam int DW = $clog2(MAX_FRAMES + 1);
  localparam int CW = (DW > rbp_pkg::FRAMES_W) ? DW : rbp_pkg::FRAMES_W;
  localparam int CB = COUNT_BITS;
  localparam logic signed [CB-1:0] CNT_MAX = {1'b0, {(CB-1){1'b1}}};
  localparam logic signed [CB-1:0] CNT_MIN = {1'b1, {(CB-1){1'b0}}};
  localparam logic signed [CB-1:0] CNT_ONE = CB'(1);

  // Memories: free stack and {owned, count} per frame
  logic [IW-1:0] stk_mem [MAX_FRAMES];
  logic [CB:0]   cnt_mem [MAX_FRAMES];

  rbp_pkg::bk_state_t state_r, state_nxt;
  rbp_pkg::cmd_op_t   op_r, op_nxt;
  logic [rbp_pkg::INDEX_W-1:0]  idx_r, idx_nxt;
  logic [DW-1:0]                depth_r, depth_nxt;
  logic                         sweeping_r;
  logic [IW-1:0]                sweep_r;
  logic [rbp_pkg::INDEX_W-1:0]  gidx_r, gidx_nxt;
  logic [rbp_pkg::FRAMES_W-1:0] opnd_r, opnd_nxt;
  logic [rbp_pkg::REFCNT_W-1:0] cnt_out_r, cnt_out_nxt;
  logic [rbp_pkg::STATUS_W-1:0] status_r, status_nxt;
  logic [IW-1:0]                stk_rd_r;
  logic [CB:0]                  cnt_rd_r;

  logic          stk_re, cnt_re;
  logic [IW-1:0] stk_raddr, cnt_raddr;
  logic          stk_we, cnt_we;
  logic [IW-1:0] stk_waddr, cnt_waddr;
  logic [IW-1:0] stk_wdata;
  logic [CB:0]   cnt_wdata;
  logic          ex_stk_we, ex_cnt_we;
  logic [IW-1:0] ex_stk_waddr, ex_cnt_waddr;
  logic [IW-1:0] ex_stk_wdata;
  logic [CB:0]   ex_cnt_wdata;

  logic signed [CB-1:0] cnt_old, cnt_new;
  logic signed [31:0]   cnt_wide;
  logic                 owned_old, release_hit, room;

  assign sweeping = sweeping_r;
  assign room     = (CW'(depth_r) < CW'(cfg.frames_in_use));

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      rbp_pkg::BK_IDLE: begin
        if (!sweeping_r && !cfg.reload && !cmd_empty) begin
          if (cmd.op == rbp_pkg::OP_REJECT ||
              (cmd.op == rbp_pkg::OP_ACQUIRE && depth_r == '0)) begin
            state_nxt = rbp_pkg::BK_MUL;
          end else begin
            state_nxt = rbp_pkg::BK_EXEC;
          end
        end
      end
      rbp_pkg::BK_EXEC: state_nxt = rbp_pkg::BK_MUL;
      rbp_pkg::BK_MUL: begin
        if (!res_full) begin
          state_nxt = rbp_pkg::BK_IDLE;
        end
      end
      default: state_nxt = rbp_pkg::BK_IDLE;
    endcase
  end

  // Count update for ref and unref
  always_comb begin
    cnt_old   = cnt_rd_r[CB-1:0];
    owned_old = cnt_rd_r[CB];
    if (op_r == rbp_pkg::OP_REF) begin
      cnt_new = (cnt_old != CNT_MAX) ? cnt_old + CNT_ONE : cnt_old;
    end else begin
      cnt_new = (cnt_old != CNT_MIN) ? cnt_old - CNT_ONE : cnt_old;
    end
    release_hit = (op_r == rbp_pkg::OP_UNREF) && owned_old &&
                  (cnt_new[CB-1] || cnt_new == '0);
    cnt_wide = 32'(cnt_new);
  end

  // Outputs of the sequencer
  always_comb begin
    cmd_pop      = 1'b0;
    stk_re       = 1'b0;
    cnt_re       = 1'b0;
    stk_raddr    = IW'(depth_r - DW'(1));
    cnt_raddr    = IW'(cmd.idx);
    ex_stk_we    = 1'b0;
    ex_stk_waddr = IW'(depth_r);
    ex_stk_wdata = IW'(idx_r);
    ex_cnt_we    = 1'b0;
    ex_cnt_waddr = IW'(idx_r);
    ex_cnt_wdata = {owned_old & !release_hit, cnt_new};
    res_push     = 1'b0;
    op_nxt       = op_r;
    idx_nxt      = idx_r;
    depth_nxt    = depth_r;
    gidx_nxt     = gidx_r;
    opnd_nxt     = opnd_r;
    cnt_out_nxt  = cnt_out_r;
    status_nxt   = status_r;
    unique case (state_r)
      rbp_pkg::BK_IDLE: begin
        if (!sweeping_r && !cfg.reload && !cmd_empty) begin
          cmd_pop     = 1'b1;
          op_nxt      = cmd.op;
          idx_nxt     = cmd.idx;
          opnd_nxt    = '0;
          cnt_out_nxt = '0;
          gidx_nxt    = '0;
          stk_re      = (cmd.op == rbp_pkg::OP_ACQUIRE) && (depth_r != '0);
          cnt_re      = (cmd.op == rbp_pkg::OP_REF) || (cmd.op == rbp_pkg::OP_UNREF);
          if (cmd.op == rbp_pkg::OP_REJECT) begin
            gidx_nxt   = cmd.idx;
            status_nxt = rbp_pkg::STAT_BAD;
          end else begin
            status_nxt = rbp_pkg::STAT_EMPTY;
          end
        end
      end
      rbp_pkg::BK_EXEC: begin
        if (op_r == rbp_pkg::OP_ACQUIRE) begin
          // pop the top frame, count 1, owned
          ex_cnt_we    = 1'b1;
          ex_cnt_waddr = stk_rd_r;
          ex_cnt_wdata = {1'b1, CNT_ONE};
          depth_nxt    = depth_r - DW'(1);
          gidx_nxt     = rbp_pkg::INDEX_W'(stk_rd_r);
          opnd_nxt     = rbp_pkg::FRAMES_W'(stk_rd_r);
          cnt_out_nxt  = rbp_pkg::REFCNT_W'(1);
          status_nxt   = rbp_pkg::STAT_OK;
        end else begin
          ex_cnt_we   = 1'b1;
          gidx_nxt    = idx_r;
          opnd_nxt    = rbp_pkg::FRAMES_W'(idx_r);
          cnt_out_nxt = cnt_wide[rbp_pkg::REFCNT_W-1:0];
          status_nxt  = release_hit ? rbp_pkg::STAT_RETURNED : rbp_pkg::STAT_OK;
          // released frame goes back on the stack if there is room
          if (release_hit && room) begin
            ex_stk_we = 1'b1;
            depth_nxt = depth_r + DW'(1);
          end
        end
      end
      rbp_pkg::BK_MUL: begin
        res_push = !res_full;
      end
      default: begin
      end
    endcase
    if (cfg.reload) begin
      depth_nxt = DW'(cfg.frames_in_use);
    end
  end

  // Result beat: offset product lands in the result queue register
  always_comb begin
    res.granted_index = gidx_r;
    res.byte_offset   = rbp_pkg::OFFSET_W'(opnd_r * cfg.frame_bytes);
    res.ref_count     = cnt_out_r;
    res.free_left     = rbp_pkg::FREE_W'(depth_r);
    res.status        = status_r;
  end

  // Memory write ports: rebuild sweep or operation
  always_comb begin
    if (sweeping_r) begin
      stk_we    = 1'b1;
      stk_waddr = sweep_r;
      stk_wdata = sweep_r;
      cnt_we    = 1'b1;
      cnt_waddr = sweep_r;
      cnt_wdata = {1'b1, {CB{1'b0}}};
    end else begin
      stk_we    = ex_stk_we;
      stk_waddr = ex_stk_waddr;
      stk_wdata = ex_stk_wdata;
      cnt_we    = ex_cnt_we;
      cnt_waddr = ex_cnt_waddr;
      cnt_wdata = ex_cnt_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (stk_we) begin
      stk_mem[stk_waddr] <= stk_wdata;
    end
    if (stk_re) begin
      stk_rd_r <= stk_mem[stk_raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (cnt_we) begin
      cnt_mem[cnt_waddr] <= cnt_wdata;
    end
    if (cnt_re) begin
      cnt_rd_r <= cnt_mem[cnt_raddr];
    end
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= rbp_pkg::BK_IDLE;
      depth_r    <= DW'(rbp_pkg::reset_frames(MAX_FRAMES));
      sweeping_r <= 1'b1;
      sweep_r    <= '0;
    end else begin
      state_r <= state_nxt;
      depth_r <= depth_nxt;
      if (cfg.reload) begin
        sweeping_r <= 1'b1;
        sweep_r    <= '0;
      end else if (sweeping_r) begin
        sweep_r <= sweep_r + IW'(1);
        if (sweep_r == IW'(MAX_FRAMES - 1)) begin
          sweeping_r <= 1'b0;
        end
      end
    end
  end

  // Operation payload
  always_ff @(posedge clk) begin
    op_r      <= op_nxt;
    idx_r     <= idx_nxt;
    gidx_r    <= gidx_nxt;
    opnd_r    <= opnd_nxt;
    cnt_out_r <= cnt_out_nxt;
    status_r  <= status_nxt;
  end

endmodule

`default_nettype wire

@@ sv/refcounted_buffer_pool.sv @@
`default_nettype none

// Channel  Handshake           Payload
// in       in_push / in_full   in_item   (kind, frame_index)
// out      out_pop / out_empty out_item  (granted_index, byte_offset, ref_count,
//                                         free_left, status)
// cfg      cfg_valid/cfg_ready cfg_index, cfg_data
//
// Back sequencer: each operation runs command pop with memory read (BK_IDLE), then
// read-modify-write of the count and stack memories (BK_EXEC), then offset multiply into
// the result queue (BK_MUL); a rejected beat or an acquire on an empty pool skips BK_EXEC.
// After reset and after each frames_in_use write (via reload), a sweep of all MAX_FRAMES
// frames rebuilds the pool; in_full stays high meanwhile, cfg writes are always taken.
// A full result queue stalls the back end; a full command queue raises in_full.

module refcounted_buffer_pool #(
  parameter int MAX_FRAMES = rbp_pkg::MAX_FRAMES_DEF,
  parameter int COUNT_BITS = rbp_pkg::COUNT_BITS_DEF
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            in_push,
  input  wire rbp_pkg::in_item_t               in_item,
  output logic                                 in_full,
  output logic                                 out_empty,
  input  wire logic                            out_pop,
  output rbp_pkg::out_item_t                   out_item,
  input  wire logic                            cfg_valid,
  output logic                                 cfg_ready,
  input  wire logic [rbp_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [rbp_pkg::CFG_DATA_W-1:0] cfg_data
);

  localparam int FRAMES_RESET = rbp_pkg::reset_frames(MAX_FRAMES);

  logic [rbp_pkg::FRAMES_W-1:0] frames_r, frames_nxt;
  logic [rbp_pkg::BYTES_W-1:0]  bytes_r, bytes_nxt;
  logic                         reload_r, reload_nxt;
  logic [rbp_pkg::FRAMES_W-1:0] frames_req;
  logic [rbp_pkg::BYTES_W-1:0]  bytes_req;
  rbp_pkg::pool_cfg_t           cfg;
  logic                         sweeping;
  logic                         cmd_pop, cmd_empty;
  rbp_pkg::cmd_t                cmd;
  logic                         res_push, res_full;
  rbp_pkg::out_item_t           res;

  assign cfg_ready         = 1'b1;
  assign cfg.frames_in_use = frames_r;
  assign cfg.frame_bytes   = bytes_r;
  assign cfg.reload        = reload_r;

  // Register decode with clamping
  always_comb begin
    frames_req = cfg_data[rbp_pkg::FRAMES_W-1:0];
    if (frames_req == '0) begin
      frames_req = rbp_pkg::FRAMES_W'(1);
    end else if (32'(frames_req) > MAX_FRAMES) begin
      frames_req = rbp_pkg::FRAMES_W'(MAX_FRAMES);
    end
    bytes_req = cfg_data[rbp_pkg::BYTES_W-1:0];
    if (bytes_req == '0) begin
      bytes_req = rbp_pkg::BYTES_W'(1);
    end else if (bytes_req > rbp_pkg::BYTES_LIMIT) begin
      bytes_req = rbp_pkg::BYTES_LIMIT;
    end
    frames_nxt = frames_r;
    bytes_nxt  = bytes_r;
    reload_nxt = 1'b0;
    if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        rbp_pkg::CFG_FRAMES: begin
          frames_nxt = frames_req;
          reload_nxt = 1'b1;
        end
        rbp_pkg::CFG_BYTES: bytes_nxt = bytes_req;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frames_r <= rbp_pkg::FRAMES_W'(FRAMES_RESET);
      bytes_r  <= rbp_pkg::BYTES_RESET;
      reload_r <= 1'b0;
    end else begin
      frames_r <= frames_nxt;
      bytes_r  <= bytes_nxt;
      reload_r <= reload_nxt;
    end
  end

  rbp_front #(
    .DEPTH (rbp_pkg::QUEUE_DEPTH)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg),
    .sweeping  (sweeping),
    .in_push   (in_push),
    .in_item   (in_item),
    .in_full   (in_full),
    .cmd_pop   (cmd_pop),
    .cmd       (cmd),
    .cmd_empty (cmd_empty)
  );

  rbp_back #(
    .MAX_FRAMES (MAX_FRAMES),
    .COUNT_BITS (COUNT_BITS)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg),
    .sweeping  (sweeping),
    .cmd_empty (cmd_empty),
    .cmd       (cmd),
    .cmd_pop   (cmd_pop),
    .res_full  (res_full),
    .res_push  (res_push),
    .res       (res)
  );

  rbp_fifo #(
    .T     (rbp_pkg::out_item_t),
    .DEPTH (rbp_pkg::QUEUE_DEPTH)
  ) u_res_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (res_push),
    .wdata (res),
    .full  (res_full),
    .pop   (out_pop),
    .rdata (out_item),
    .empty (out_empty)
  );

endmodule

`default_nettype wire
